>>> rtl/dmc_pkg.sv
package dmc_pkg;

	localparam int unsigned POS_W = 10;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_OP = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_XID = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_XID = 2'd2;

	localparam logic [POS_W-1:0] POS_OP = 10'd0;
	localparam logic [POS_W-1:0] POS_HTYPE = 10'd1;
	localparam logic [POS_W-1:0] POS_HLEN = 10'd2;
	localparam logic [POS_W-3:0] POS_XID_WORD = 8'd1;      // offsets 4..7
	localparam logic [POS_W-3:0] POS_COOKIE_WORD = 8'd59;  // offsets 236..239
	localparam logic [POS_W-1:0] POS_OPTIONS = 10'd240;
	localparam logic [POS_W-1:0] POS_LAST_HEADER = 10'd239;

	localparam logic [7:0] HTYPE_ETHERNET = 8'd1;
	localparam logic [7:0] HLEN_ETHERNET = 8'd6;

	localparam logic [7:0] OPT_PAD = 8'd0;
	localparam logic [7:0] OPT_END = 8'd255;
	localparam logic [7:0] OPT_REQ_ADDR = 8'd50;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SRV_ADDR = 8'd54;

	localparam logic [7:0] LEN_MSG_TYPE = 8'd1;
	localparam logic [7:0] LEN_ADDRESS = 8'd4;

	localparam logic [7:0] COOKIE [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0]  expected_op;
		logic [31:0] expected_transaction;
		logic        check_transaction;
	} cfg_t;

	typedef struct packed {
		logic        message_valid;
		logic [7:0]  message_kind;
		logic [31:0] server_address;
		logic [31:0] requested_address;
	} result_t;

endpackage

>>> rtl/dmc_walk.sv
module dmc_walk #(
	parameter int unsigned MAX_MESSAGE_BYTES = 548
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        msg_byte,
	input  logic              final_byte,
	input  dmc_pkg::cfg_t     cfg,
	output dmc_pkg::result_t  result
);

	localparam logic [dmc_pkg::POS_W-1:0] MAX_POS = MAX_MESSAGE_BYTES[dmc_pkg::POS_W-1:0];

	logic [dmc_pkg::POS_W-1:0] pos_q, pos_d;
	dmc_pkg::phase_t           phase_q, phase_d;
	logic [7:0]                left_q, left_d;
	logic [7:0]                code_q, code_d;
	logic                      hdr_ok_q, hdr_ok_d;
	logic                      xid_ok_q, xid_ok_d;
	logic                      kind_seen_q, kind_seen_d;
	logic [7:0]                kind_q, kind_d;
	logic                      srv_seen_q, srv_seen_d;
	logic [31:0]               srv_q, srv_d;
	logic                      req_seen_q, req_seen_d;
	logic [31:0]               req_q, req_d;
	logic                      too_long_q, too_long_d;
	logic                      collect_q, collect_d;

	logic [7:0] xid_byte;
	logic       cut;

	always_comb begin
		case (pos_q[1:0])
			2'd0:    xid_byte = cfg.expected_transaction[31:24];
			2'd1:    xid_byte = cfg.expected_transaction[23:16];
			2'd2:    xid_byte = cfg.expected_transaction[15:8];
			default: xid_byte = cfg.expected_transaction[7:0];
		endcase
	end

	// per-byte update of the message state
	always_comb begin
		phase_d     = phase_q;
		left_d      = left_q;
		code_d      = code_q;
		hdr_ok_d    = hdr_ok_q;
		xid_ok_d    = xid_ok_q;
		kind_seen_d = kind_seen_q;
		kind_d      = kind_q;
		srv_seen_d  = srv_seen_q;
		srv_d       = srv_q;
		req_seen_d  = req_seen_q;
		req_d       = req_q;
		collect_d   = collect_q;
		too_long_d  = too_long_q | (pos_q >= MAX_POS);
		pos_d       = (pos_q != '1) ? pos_q + 1'b1 : pos_q;

		if (!too_long_d) begin
			if (pos_q == dmc_pkg::POS_OP && msg_byte != cfg.expected_op)
				hdr_ok_d = 1'b0;
			if (pos_q == dmc_pkg::POS_HTYPE && msg_byte != dmc_pkg::HTYPE_ETHERNET)
				hdr_ok_d = 1'b0;
			if (pos_q == dmc_pkg::POS_HLEN && msg_byte != dmc_pkg::HLEN_ETHERNET)
				hdr_ok_d = 1'b0;
			if (pos_q[dmc_pkg::POS_W-1:2] == dmc_pkg::POS_XID_WORD && msg_byte != xid_byte)
				xid_ok_d = 1'b0;
			if (pos_q[dmc_pkg::POS_W-1:2] == dmc_pkg::POS_COOKIE_WORD &&
			    msg_byte != dmc_pkg::COOKIE[pos_q[1:0]])
				hdr_ok_d = 1'b0;

			if (pos_q >= dmc_pkg::POS_OPTIONS) begin
				unique case (phase_q)
					dmc_pkg::PH_CODE: begin
						if (msg_byte == dmc_pkg::OPT_END) begin
							phase_d = dmc_pkg::PH_DONE;
						end else if (msg_byte != dmc_pkg::OPT_PAD) begin
							code_d  = msg_byte;
							phase_d = dmc_pkg::PH_LEN;
						end
					end
					dmc_pkg::PH_LEN: begin
						left_d    = msg_byte;
						collect_d = 1'b0;
						if (code_q == dmc_pkg::OPT_MSG_TYPE && !kind_seen_q) begin
							kind_seen_d = 1'b1;
							kind_d      = '0;
							collect_d   = (msg_byte == dmc_pkg::LEN_MSG_TYPE);
						end else if (code_q == dmc_pkg::OPT_SRV_ADDR && !srv_seen_q) begin
							srv_seen_d = 1'b1;
							srv_d      = '0;
							collect_d  = (msg_byte == dmc_pkg::LEN_ADDRESS);
						end else if (code_q == dmc_pkg::OPT_REQ_ADDR && !req_seen_q) begin
							req_seen_d = 1'b1;
							req_d      = '0;
							collect_d  = (msg_byte == dmc_pkg::LEN_ADDRESS);
						end
						phase_d = (msg_byte != 8'd0) ? dmc_pkg::PH_VALUE : dmc_pkg::PH_CODE;
					end
					dmc_pkg::PH_VALUE: begin
						if (collect_q) begin
							if (code_q == dmc_pkg::OPT_MSG_TYPE)
								kind_d = msg_byte;
							else if (code_q == dmc_pkg::OPT_SRV_ADDR)
								srv_d = {srv_q[23:0], msg_byte};
							else
								req_d = {req_q[23:0], msg_byte};
						end
						left_d = left_q - 8'd1;
						if (left_d == 8'd0) begin
							collect_d = 1'b0;
							phase_d   = dmc_pkg::PH_CODE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result as seen after the final byte; an option cut short reads as absent
	always_comb begin
		cut = collect_d && (left_d != 8'd0);
		if (too_long_d) begin
			result = '0;
		end else begin
			result.message_valid     = (pos_q >= dmc_pkg::POS_LAST_HEADER) && hdr_ok_d &&
			                           (!cfg.check_transaction || xid_ok_d);
			result.message_kind      = (cut && code_d == dmc_pkg::OPT_MSG_TYPE) ? 8'd0 : kind_d;
			result.server_address    = (cut && code_d == dmc_pkg::OPT_SRV_ADDR) ? 32'd0 : srv_d;
			result.requested_address = (cut && code_d == dmc_pkg::OPT_REQ_ADDR) ? 32'd0 : req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			phase_q     <= dmc_pkg::PH_CODE;
			left_q      <= '0;
			code_q      <= '0;
			hdr_ok_q    <= 1'b1;
			xid_ok_q    <= 1'b1;
			kind_seen_q <= 1'b0;
			kind_q      <= '0;
			srv_seen_q  <= 1'b0;
			srv_q       <= '0;
			req_seen_q  <= 1'b0;
			req_q       <= '0;
			too_long_q  <= 1'b0;
			collect_q   <= 1'b0;
		end else if (step) begin
			if (final_byte) begin
				pos_q       <= '0;
				phase_q     <= dmc_pkg::PH_CODE;
				left_q      <= '0;
				code_q      <= '0;
				hdr_ok_q    <= 1'b1;
				xid_ok_q    <= 1'b1;
				kind_seen_q <= 1'b0;
				kind_q      <= '0;
				srv_seen_q  <= 1'b0;
				srv_q       <= '0;
				req_seen_q  <= 1'b0;
				req_q       <= '0;
				too_long_q  <= 1'b0;
				collect_q   <= 1'b0;
			end else begin
				pos_q       <= pos_d;
				phase_q     <= phase_d;
				left_q      <= left_d;
				code_q      <= code_d;
				hdr_ok_q    <= hdr_ok_d;
				xid_ok_q    <= xid_ok_d;
				kind_seen_q <= kind_seen_d;
				kind_q      <= kind_d;
				srv_seen_q  <= srv_seen_d;
				srv_q       <= srv_d;
				req_seen_q  <= req_seen_d;
				req_q       <= req_d;
				too_long_q  <= too_long_d;
				collect_q   <= collect_d;
			end
		end
	end

endmodule

>>> rtl/dhcp_message_check_and_option_extract.sv
// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------------
// in       | in_valid / in_ready      | msg_byte, final_byte
// out      | out_valid / out_ready    | message_valid, message_kind,
//          |                          | server_address, requested_address
// cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One byte per cycle, except that a final byte waits while the result slot is
// full. A byte goes into the input register, the option walker updates the
// message state from it as it leaves that register, and the final byte's
// result goes into the output register in that same step. Reset clears all
// message state and loads the register defaults (op 2, id 0, id check off).
// A stalled result holds only the final byte in the input register; ordinary
// bytes keep flowing.
module dhcp_message_check_and_option_extract #(
	parameter int unsigned MAX_MESSAGE_BYTES = 548
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       msg_byte,
	input  logic                             final_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             message_valid,
	output logic [7:0]                       message_kind,
	output logic [31:0]                      server_address,
	output logic [31:0]                      requested_address,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dmc_pkg::cfg_t    cfg_q;
	dmc_pkg::result_t walk_result;
	dmc_pkg::result_t result_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       out_valid_q;
	logic       step_s1;

	// config writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_op          <= 8'd2;
			cfg_q.expected_transaction <= '0;
			cfg_q.check_transaction    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dmc_pkg::CFG_EXPECTED_OP:  cfg_q.expected_op          <= cfg_data[7:0];
				dmc_pkg::CFG_EXPECTED_XID: cfg_q.expected_transaction <= cfg_data;
				dmc_pkg::CFG_CHECK_XID:    cfg_q.check_transaction    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// a non-final byte always moves on; the final one waits for a free result slot
	assign step_s1  = valid_s1 && (!final_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= msg_byte;
			final_s1 <= final_byte;
		end
	end

	dmc_walk #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step_s1),
		.msg_byte   (byte_s1),
		.final_byte (final_s1),
		.cfg        (cfg_q),
		.result     (walk_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1 && final_s1) begin
			result_q <= walk_result;
		end
	end

	assign out_valid         = out_valid_q;
	assign message_valid     = result_q.message_valid;
	assign message_kind      = result_q.message_kind;
	assign server_address    = result_q.server_address;
	assign requested_address = result_q.requested_address;

endmodule

>>> test/tb_dhcp_message_check_and_option_extract.sv
`timescale 1ns / 100ps

module tb_dhcp_message_check_and_option_extract;

	localparam int MAX_BYTES = 548;
	localparam int HALF_PERIOD = 4;
	// no register here, write is dropped
	localparam logic [dmc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [7:0] OP_REQUEST = 8'd1;
	localparam logic [7:0] OP_REPLY = 8'd2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] msg_byte = 8'd0;
	logic final_byte = 1'b0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [dmc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [dmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic in_ready;
	logic out_valid;
	logic message_valid;
	logic [7:0] message_kind;
	logic [31:0] server_address;
	logic [31:0] requested_address;
	logic cfg_ready;

	always #HALF_PERIOD clk = ~clk;

	dhcp_message_check_and_option_extract #(
		.MAX_MESSAGE_BYTES(MAX_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.msg_byte(msg_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.message_valid(message_valid),
		.message_kind(message_kind),
		.server_address(server_address),
		.requested_address(requested_address),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------
	// Parser model: register shadow plus per-message state
	// ------------------------------------------------------------------
	dmc_pkg::cfg_t shadow_cfg;
	logic [dmc_pkg::POS_W-1:0] at_pos;
	dmc_pkg::phase_t walk;
	logic [7:0] opt_left;
	logic [7:0] opt_code;
	logic header_good;
	logic xid_good;
	logic [8:0] kind_cap;      // bit 8: option already seen
	logic [32:0] server_cap;   // bit 32: option already seen
	logic [32:0] request_cap;
	logic oversize;
	logic capturing;           // current option value is being collected

	dmc_pkg::result_t pending_results[$];
	int mismatches = 0;
	int bytes_sent = 0;
	int burst_left = 0;

	// register values as last written by the stimulus side
	logic [7:0] cur_op;
	logic [31:0] cur_xid;

	logic [7:0] frame[$];

	function automatic void clear_message();
		at_pos = '0;
		walk = dmc_pkg::PH_CODE;
		opt_left = 8'd0;
		opt_code = 8'd0;
		header_good = 1'b1;
		xid_good = 1'b1;
		kind_cap = '0;
		server_cap = '0;
		request_cap = '0;
		oversize = 1'b0;
		capturing = 1'b0;
	endfunction

	function automatic void apply_register(input logic [dmc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [dmc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			dmc_pkg::CFG_EXPECTED_OP: shadow_cfg.expected_op = data[7:0];
			dmc_pkg::CFG_EXPECTED_XID: shadow_cfg.expected_transaction = data;
			dmc_pkg::CFG_CHECK_XID: shadow_cfg.check_transaction = data[0];
			default: ;
		endcase
	endfunction

	// One byte into the model; the final byte queues its expected result.
	function automatic void absorb_byte(input logic [7:0] b, input logic last);
		logic [dmc_pkg::POS_W-1:0] pos;
		int sh;
		logic cut;
		dmc_pkg::result_t want;
		pos = at_pos;
		sh = 24 - 8 * pos[1:0];
		if (pos >= MAX_BYTES)
			oversize = 1'b1;
		if (!oversize) begin
			if (pos == dmc_pkg::POS_OP && b != shadow_cfg.expected_op)
				header_good = 1'b0;
			if (pos == dmc_pkg::POS_HTYPE && b != dmc_pkg::HTYPE_ETHERNET)
				header_good = 1'b0;
			if (pos == dmc_pkg::POS_HLEN && b != dmc_pkg::HLEN_ETHERNET)
				header_good = 1'b0;
			if (pos[dmc_pkg::POS_W-1:2] == dmc_pkg::POS_XID_WORD &&
					b != shadow_cfg.expected_transaction[sh +: 8])
				xid_good = 1'b0;
			if (pos[dmc_pkg::POS_W-1:2] == dmc_pkg::POS_COOKIE_WORD &&
					b != dmc_pkg::COOKIE[pos[1:0]])
				header_good = 1'b0;
			if (pos >= dmc_pkg::POS_OPTIONS) begin
				case (walk)
					dmc_pkg::PH_CODE: begin
						if (b == dmc_pkg::OPT_END) begin
							walk = dmc_pkg::PH_DONE;
						end else if (b != dmc_pkg::OPT_PAD) begin
							opt_code = b;
							walk = dmc_pkg::PH_LEN;
						end
					end
					dmc_pkg::PH_LEN: begin
						// only the first option of a captured code counts, good length or not
						opt_left = b;
						capturing = 1'b0;
						if (opt_code == dmc_pkg::OPT_MSG_TYPE && !kind_cap[8]) begin
							kind_cap = 9'h100;
							capturing = (b == dmc_pkg::LEN_MSG_TYPE);
						end else if (opt_code == dmc_pkg::OPT_SRV_ADDR && !server_cap[32]) begin
							server_cap = {1'b1, 32'd0};
							capturing = (b == dmc_pkg::LEN_ADDRESS);
						end else if (opt_code == dmc_pkg::OPT_REQ_ADDR && !request_cap[32]) begin
							request_cap = {1'b1, 32'd0};
							capturing = (b == dmc_pkg::LEN_ADDRESS);
						end
						walk = (b != 8'd0) ? dmc_pkg::PH_VALUE : dmc_pkg::PH_CODE;
					end
					dmc_pkg::PH_VALUE: begin
						if (capturing) begin
							if (opt_code == dmc_pkg::OPT_MSG_TYPE)
								kind_cap = {1'b1, b};
							else if (opt_code == dmc_pkg::OPT_SRV_ADDR)
								server_cap = {1'b1, server_cap[23:0], b};
							else
								request_cap = {1'b1, request_cap[23:0], b};
						end
						opt_left = opt_left - 8'd1;
						if (opt_left == 8'd0) begin
							capturing = 1'b0;
							walk = dmc_pkg::PH_CODE;
						end
					end
					default: ;
				endcase
			end
		end
		if (at_pos != {dmc_pkg::POS_W{1'b1}})
			at_pos = at_pos + 1'b1;
		if (last) begin
			want = '0;
			if (!oversize) begin
				// value still running at the final byte: that option counts as absent
				cut = capturing && opt_left != 8'd0;
				want.message_valid = (pos >= dmc_pkg::POS_LAST_HEADER) && header_good &&
					(!shadow_cfg.check_transaction || xid_good);
				want.message_kind = (cut && opt_code == dmc_pkg::OPT_MSG_TYPE) ?
					8'd0 : kind_cap[7:0];
				want.server_address = (cut && opt_code == dmc_pkg::OPT_SRV_ADDR) ?
					32'd0 : server_cap[31:0];
				want.requested_address = (cut && opt_code == dmc_pkg::OPT_REQ_ADDR) ?
					32'd0 : request_cap[31:0];
			end
			pending_results.push_back(want);
			clear_message();
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sample transfers before this edge's updates land
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		dmc_pkg::result_t want;
		if (arst_n) begin
			// a result passes the input and output registers before it can be taken, so checking before predicting is safe
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: valid %0d kind %0d server %h requested %h",
							message_valid, message_kind, server_address, requested_address);
				end else begin
					want = pending_results.pop_front();
					if (message_valid !== want.message_valid ||
							message_kind !== want.message_kind ||
							server_address !== want.server_address ||
							requested_address !== want.requested_address) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected valid %0d kind %0d server %h requested %h",
								want.message_valid, want.message_kind,
								want.server_address, want.requested_address);
							$display("          got      valid %0d kind %0d server %h requested %h",
								message_valid, message_kind, server_address,
								requested_address);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				absorb_byte(msg_byte, final_byte);
		end
	end

	// Receiver back-pressure: mode is redrawn each time the tick counter wraps; mode 0 never stalls.
	logic [7:0] rx_tick = 8'd0;
	int rx_mode = 0;
	always @(posedge clk) begin
		rx_tick <= rx_tick + 8'd1;
		if (rx_tick == 8'd0)
			rx_mode <= $urandom_range(3);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(3) != 0);
			2: out_ready <= (rx_tick[3:2] == 2'b00);
			default: out_ready <= ($urandom_range(1) != 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Frame building
	// ------------------------------------------------------------------
	function automatic void add_byte(input logic [7:0] b);
		frame.push_back(b);
	endfunction

	// fixed header with random filler, given op and transaction id
	function automatic void start_frame(input logic [7:0] op, input logic [31:0] xid);
		frame.delete();
		for (int i = 0; i < dmc_pkg::POS_OPTIONS; i++)
			frame.push_back(8'($urandom_range(255)));
		frame[dmc_pkg::POS_OP] = op;
		frame[dmc_pkg::POS_HTYPE] = dmc_pkg::HTYPE_ETHERNET;
		frame[dmc_pkg::POS_HLEN] = dmc_pkg::HLEN_ETHERNET;
		for (int k = 0; k < 4; k++) begin
			frame[4 + k] = xid[24 - 8 * k +: 8];
			frame[dmc_pkg::POS_OPTIONS - 4 + k] = dmc_pkg::COOKIE[k];
		end
	endfunction

	function automatic void corrupt(input int idx);
		frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
	endfunction

	function automatic void trim_frame(input int n);
		while (frame.size() > n)
			void'(frame.pop_back());
	endfunction

	function automatic void add_kind(input logic [7:0] v);
		add_byte(dmc_pkg::OPT_MSG_TYPE);
		add_byte(dmc_pkg::LEN_MSG_TYPE);
		add_byte(v);
	endfunction

	function automatic void add_addr(input logic [7:0] code, input logic [31:0] v);
		add_byte(code);
		add_byte(dmc_pkg::LEN_ADDRESS);
		for (int k = 0; k < 4; k++)
			add_byte(v[24 - 8 * k +: 8]);
	endfunction

	function automatic void add_opaque(input logic [7:0] code, input int len);
		add_byte(code);
		add_byte(8'(len));
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom_range(255)));
	endfunction

	function automatic void add_random_option();
		case ($urandom_range(7))
			0: add_byte(dmc_pkg::OPT_PAD);
			1: add_kind(8'($urandom_range(255)));
			2: add_addr(dmc_pkg::OPT_SRV_ADDR, $urandom);
			3: add_addr(dmc_pkg::OPT_REQ_ADDR, $urandom);
			4: begin
				case ($urandom_range(2))
					0: add_opaque(dmc_pkg::OPT_MSG_TYPE, $urandom_range(0, 6));
					1: add_opaque(dmc_pkg::OPT_SRV_ADDR, $urandom_range(0, 6));
					default: add_opaque(dmc_pkg::OPT_REQ_ADDR, $urandom_range(0, 6));
				endcase
			end
			default: add_opaque(8'($urandom_range(1, 254)), $urandom_range(0, 12));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------
	// Sender works in bursts; valid drops only during a gap.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		msg_byte <= b;
		final_byte <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame();
		int n;
		n = frame.size();
		for (int i = 0; i < n; i++)
			send_byte(frame[i], i == n - 1);
	endtask

	// valid is left high between back-to-back writes; the caller lowers it
	task automatic write_reg(input logic [dmc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Registers only change with the parser idle. Unused data bits are randomized.
	task automatic set_config(input logic [7:0] op, input logic [31:0] xid, input logic chk);
		logic [31:0] junk;
		wait_drained();
		junk = $urandom;
		junk[7:0] = op;
		write_reg(dmc_pkg::CFG_EXPECTED_OP, junk);
		write_reg(dmc_pkg::CFG_EXPECTED_XID, xid);
		junk = $urandom;
		junk[0] = chk;
		write_reg(dmc_pkg::CFG_CHECK_XID, junk);
		cfg_valid <= 1'b0;
		cur_op = op;
		cur_xid = xid;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// reset values of the registers: replies pass, requests fail
	task automatic test_register_defaults();
		start_frame(OP_REPLY, $urandom);
		add_kind(8'd5);
		add_addr(dmc_pkg::OPT_SRV_ADDR, 32'hC0A8_0101);
		add_addr(dmc_pkg::OPT_REQ_ADDR, 32'h0A00_00FE);
		add_byte(dmc_pkg::OPT_END);
		send_frame();
		start_frame(OP_REQUEST, $urandom);
		add_kind(8'd3);
		add_byte(dmc_pkg::OPT_END);
		send_frame();
	endtask

	task automatic test_header_fields();
		start_frame(cur_op, cur_xid);
		corrupt(dmc_pkg::POS_HTYPE);
		add_kind(8'd1);
		send_frame();
		start_frame(cur_op, cur_xid);
		corrupt(dmc_pkg::POS_HLEN);
		send_frame();
		for (int k = 0; k < 4; k++) begin
			start_frame(cur_op, cur_xid);
			corrupt(dmc_pkg::POS_OPTIONS - 4 + k);
			add_addr(dmc_pkg::OPT_SRV_ADDR, $urandom);
			send_frame();
		end
	endtask

	// short, one under the minimum, exact-minimum, exact-maximum, one over, and past position saturation
	task automatic test_length_limits();
		frame.delete();
		add_byte(8'($urandom_range(255)));
		send_frame();
		start_frame(cur_op, cur_xid);
		trim_frame(int'(dmc_pkg::POS_LAST_HEADER));
		send_frame();
		start_frame(cur_op, cur_xid);
		send_frame();
		for (int n = MAX_BYTES; n <= MAX_BYTES + 1; n++) begin
			start_frame(cur_op, cur_xid);
			add_kind(8'd8);
			add_addr(dmc_pkg::OPT_SRV_ADDR, 32'h0102_0304);
			while (frame.size() < n - 1)
				add_byte(dmc_pkg::OPT_PAD);
			add_byte(dmc_pkg::OPT_END);
			send_frame();
		end
		start_frame(cur_op, cur_xid);
		while (frame.size() < 1030)
			add_byte(8'($urandom_range(255)));
		send_frame();
	endtask

	task automatic test_option_walk();
		// pads, unknown option, then end: later options are ignored
		start_frame(cur_op, cur_xid);
		repeat (3) add_byte(dmc_pkg::OPT_PAD);
		add_kind(8'd1);
		add_opaque(8'd12, 5);
		add_byte(dmc_pkg::OPT_END);
		add_kind(8'd7);
		add_addr(dmc_pkg::OPT_SRV_ADDR, 32'hDEAD_BEEF);
		send_frame();
		// first occurrence decides even when its length is wrong
		start_frame(cur_op, cur_xid);
		add_opaque(dmc_pkg::OPT_MSG_TYPE, 2);
		add_kind(8'd3);
		add_opaque(dmc_pkg::OPT_SRV_ADDR, 3);
		add_addr(dmc_pkg::OPT_SRV_ADDR, 32'h0A0B_0C0D);
		add_addr(dmc_pkg::OPT_REQ_ADDR, 32'hFFFF_FFFF);
		add_addr(dmc_pkg::OPT_REQ_ADDR, 32'h1111_2222);
		add_byte(dmc_pkg::OPT_END);
		send_frame();
		// zero-length and maximum-length options, extreme values
		start_frame(cur_op, cur_xid);
		add_opaque(8'd61, 0);
		add_opaque(dmc_pkg::OPT_REQ_ADDR, 0);
		add_opaque(8'd254, 255);
		add_addr(dmc_pkg::OPT_SRV_ADDR, 32'h0000_0000);
		add_kind(8'hFF);
		add_byte(dmc_pkg::OPT_END);
		send_frame();
		// server id cut short by the final byte
		start_frame(cur_op, cur_xid);
		add_kind(8'd5);
		add_byte(dmc_pkg::OPT_SRV_ADDR);
		add_byte(dmc_pkg::LEN_ADDRESS);
		add_byte(8'hAB);
		add_byte(8'hCD);
		send_frame();
		// frame ends on an option code
		start_frame(cur_op, cur_xid);
		add_addr(dmc_pkg::OPT_REQ_ADDR, 32'h8000_0001);
		add_byte(dmc_pkg::OPT_MSG_TYPE);
		send_frame();
		// frame ends on a length byte
		start_frame(cur_op, cur_xid);
		add_kind(8'd2);
		add_byte(dmc_pkg::OPT_REQ_ADDR);
		add_byte(dmc_pkg::LEN_ADDRESS);
		send_frame();
		// unrelated option cut short: captured server id stays
		start_frame(cur_op, cur_xid);
		add_addr(dmc_pkg::OPT_SRV_ADDR, 32'h5566_7788);
		add_byte(8'd43);
		add_byte(8'd20);
		repeat (3) add_byte(8'($urandom_range(255)));
		send_frame();
	endtask

	task automatic test_transaction_check();
		logic [31:0] xid;
		xid = 32'hA5C3_0FF0;
		// write to an unused index first: must leave the registers alone
		wait_drained();
		write_reg(CFG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
		set_config(OP_REQUEST, xid, 1'b1);
		start_frame(OP_REQUEST, xid);
		add_kind(8'd1);
		add_byte(dmc_pkg::OPT_END);
		send_frame();
		start_frame(OP_REQUEST, xid);
		corrupt(4 + $urandom_range(3));
		add_kind(8'd1);
		send_frame();
		set_config(8'hFF, 32'hFFFF_FFFF, 1'b1);
		start_frame(8'hFF, 32'hFFFF_FFFF);
		add_addr(dmc_pkg::OPT_REQ_ADDR, $urandom);
		send_frame();
		set_config(8'h00, 32'h0000_0000, 1'b1);
		start_frame(8'h00, 32'h0000_0000);
		add_kind(8'd4);
		send_frame();
		start_frame(8'h00, 32'h0000_0001);
		send_frame();
	endtask

	function automatic void make_random_frame();
		int sel;
		int spot;
		logic [7:0] op;
		logic [31:0] xid;
		sel = $urandom_range(99);
		op = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : cur_op;
		xid = ($urandom_range(4) == 0) ? $urandom : cur_xid;
		if (sel < 70) begin
			// well-formed frame with random options
			start_frame(op, xid);
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(3))
					0: spot = dmc_pkg::POS_OP;
					1: spot = dmc_pkg::POS_HTYPE;
					2: spot = dmc_pkg::POS_HLEN;
					default: spot = dmc_pkg::POS_OPTIONS - 4 + $urandom_range(3);
				endcase
				corrupt(spot);
			end
			repeat ($urandom_range(0, 7)) add_random_option();
			if ($urandom_range(4) != 0) begin
				add_byte(dmc_pkg::OPT_END);
				repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(255)));
			end
			if ($urandom_range(7) == 0)
				trim_frame($urandom_range(dmc_pkg::POS_OPTIONS, frame.size()));
		end else if (sel < 85) begin
			// a clipped, too short header or plain noise
			if ($urandom_range(1) == 0) begin
				start_frame(op, xid);
				trim_frame($urandom_range(1, dmc_pkg::POS_LAST_HEADER));
			end else begin
				frame.delete();
				repeat ($urandom_range(1, 250)) add_byte(8'($urandom_range(255)));
			end
		end else if (sel < 95) begin
			// valid header, garbage option area
			start_frame(op, xid);
			repeat ($urandom_range(0, 80)) add_byte(8'($urandom_range(255)));
		end else begin
			start_frame(op, xid);
			add_kind(8'($urandom_range(255)));
			while (frame.size() < $urandom_range(MAX_BYTES + 1, 620))
				add_byte(8'($urandom_range(255)));
		end
	endfunction

	task automatic test_random_traffic();
		int frames;
		int first_byte;
		frames = 0;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < 1700) begin
			if (frames % 8 == 0) begin
				case ($urandom_range(4))
					0: set_config(8'h00, 32'h0000_0000, 1'($urandom_range(1)));
					1: set_config(8'hFF, 32'hFFFF_FFFF, 1'($urandom_range(1)));
					2: set_config(OP_REQUEST, $urandom, 1'($urandom_range(1)));
					3: set_config(OP_REPLY, $urandom, 1'($urandom_range(1)));
					default: set_config(8'($urandom_range(255)), $urandom,
						1'($urandom_range(1)));
				endcase
			end
			make_random_frame();
			send_frame();
			frames++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		shadow_cfg.expected_op = OP_REPLY;
		shadow_cfg.expected_transaction = 32'd0;
		shadow_cfg.check_transaction = 1'b0;
		cur_op = OP_REPLY;
		cur_xid = 32'd0;
		clear_message();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_defaults();
		test_header_fields();
		test_length_limits();
		test_option_walk();
		test_transaction_check();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#8000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
